// File: rtl/igmp_fg_pkg.sv
`default_nettype none

package igmp_fg_pkg;

   typedef enum logic [1:0] {
      OP_QUERY  = 2'd0,
      OP_REPORT = 2'd1,
      OP_LEAVE  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_SOURCE_MAC = 2'd0,
      CSR_SOURCE_IP  = 2'd1,
      CSR_VLAN_ID    = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   localparam int unsigned CSR_DATA_WIDTH = 48;

   localparam logic [31:0] ROUTER_ALERT_WORD = 32'h9404_0000;
   localparam logic [31:0] ALL_ROUTERS_IP    = 32'hE000_0002;
   localparam logic [31:0] ALL_HOSTS_IP      = 32'hE000_0001;
   localparam logic [7:0]  MCAST_MAC_0       = 8'h01;
   localparam logic [7:0]  MCAST_MAC_1       = 8'h00;
   localparam logic [7:0]  MCAST_OUI_LOW     = 8'h5E;
   localparam logic [6:0]  MCAST_MAC_MASK    = 7'h7F;
   localparam logic [15:0] ETYPE_IPV4        = 16'h0800;
   localparam logic [15:0] ETYPE_VLAN        = 16'h8100;

   localparam logic [7:0]  IP_VER_IHL        = 8'h46;
   localparam logic [7:0]  IP_TOS            = 8'h00;
   localparam logic [15:0] IP_TOTAL_LEN      = 16'd32;
   localparam logic [15:0] IP_IDENT          = 16'd1;
   localparam logic [15:0] IP_FRAG           = 16'd0;
   localparam logic [7:0]  IP_TTL            = 8'd1;
   localparam logic [7:0]  IP_PROTO_IGMP     = 8'd2;

   // sum of the fixed header words: 4600 + 0020 + 0001 + 0102 + 9404
   localparam logic [15:0] IP_CONST_SUM      = 16'hDB27;

   localparam logic [7:0]  IGMP_TYPE_QUERY   = 8'h11;
   localparam logic [7:0]  IGMP_TYPE_REPORT  = 8'h16;
   localparam logic [7:0]  IGMP_TYPE_LEAVE   = 8'h17;
   localparam logic [7:0]  QUERY_CODE_GROUP  = 8'd10;
   localparam logic [7:0]  QUERY_CODE_ALL    = 8'd100;
   localparam logic [7:0]  CODE_NONE         = 8'd0;

   localparam logic [5:0]  ETH_ADDR_END      = 6'd12;
   localparam logic [5:0]  VLAN_TAG_BYTES    = 6'd4;
   localparam logic [5:0]  LAST_POS_TAGGED   = 6'd49;
   localparam logic [5:0]  LAST_POS_UNTAGGED = 6'd45;

   typedef struct packed {
      logic [31:0] dst_ip;
      logic [31:0] group;
      logic [7:0]  igmp_type;
      logic [7:0]  igmp_code;
   } msg_type;

   typedef struct packed {
      msg_type     msg;
      logic [15:0] ip_cksum;
      logic [15:0] igmp_cksum;
   } frame_type;

endpackage

`default_nettype wire

// File: rtl/igmp_frame_generator.sv
// IGMPv2 frame builder.
// Request channel (req_valid/req_ready): message kind and group address.
// Response channel (rsp_valid/rsp_ready): one frame byte per transfer in wire
// order, rsp_last_byte marks the final byte. Untagged frames are 46 bytes, frames
// with a nonzero VLAN id 50 bytes.
// CSR port: csr_we writes csr_wdata into register csr_index (0 source MAC,
// 1 source IP, 2 VLAN id); write only while no frame is in flight.
// A request runs through three stages (destination select, checksum partial
// sums, checksum fold) and then loads the byte serializer; each byte passes
// through the output register. Once a frame has started, one byte leaves per
// cycle while rsp_ready is high. The serializer sets the rate, and frames
// follow each other without a gap cycle since the next request is already
// waiting in the stages. A request with kind 3 is taken and
// dropped. Reset empties all stages and clears the CSRs. When rsp_ready is
// low the output byte holds and the serializer and stages back up; nothing
// is lost or repeated.
`default_nettype none

module igmp_frame_generator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_group_addr,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_frame_byte,
   output logic             rsp_last_byte,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [igmp_fg_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   logic [47:0] source_mac_ff;
   logic [31:0] source_ip_ff;
   logic [11:0] vlan_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_mac_ff <= '0;
         source_ip_ff  <= '0;
         vlan_id_ff    <= '0;
      end else if (csr_we) begin
         unique case (igmp_fg_pkg::csr_index_type'(csr_index))
            igmp_fg_pkg::CSR_SOURCE_MAC: source_mac_ff <= csr_wdata[47:0];
            igmp_fg_pkg::CSR_SOURCE_IP:  source_ip_ff  <= csr_wdata[31:0];
            igmp_fg_pkg::CSR_VLAN_ID:    vlan_id_ff    <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // stage handshake
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, ser_valid_ff, rsp_valid_ff;
   logic s1_ready, s2_ready, s3_ready, out_free, ser_emit, ser_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ser_emit  = ser_valid_ff && out_free;
   assign s3_ready  = !ser_valid_ff || (ser_emit && ser_last);
   assign s2_ready  = !s3_valid_ff || s3_ready;
   assign s1_ready  = !s2_valid_ff || s2_ready;
   assign req_ready = !s1_valid_ff || s1_ready;

   // stage 1: destination, type and code
   igmp_fg_pkg::op_type  req_op;
   igmp_fg_pkg::msg_type s1_msg_in, s1_msg_ff;
   logic                 s1_valid_in;

   assign req_op = igmp_fg_pkg::op_type'(req_operation);

   always_comb begin
      s1_msg_in.group = req_group_addr;
      unique case (req_op)
         igmp_fg_pkg::OP_QUERY: begin
            s1_msg_in.igmp_type = igmp_fg_pkg::IGMP_TYPE_QUERY;
            if (req_group_addr == '0) begin
               s1_msg_in.dst_ip    = igmp_fg_pkg::ALL_HOSTS_IP;
               s1_msg_in.igmp_code = igmp_fg_pkg::QUERY_CODE_ALL;
            end else begin
               s1_msg_in.dst_ip    = req_group_addr;
               s1_msg_in.igmp_code = igmp_fg_pkg::QUERY_CODE_GROUP;
            end
         end
         igmp_fg_pkg::OP_REPORT: begin
            s1_msg_in.igmp_type = igmp_fg_pkg::IGMP_TYPE_REPORT;
            s1_msg_in.dst_ip    = req_group_addr;
            s1_msg_in.igmp_code = igmp_fg_pkg::CODE_NONE;
         end
         igmp_fg_pkg::OP_LEAVE: begin
            s1_msg_in.igmp_type = igmp_fg_pkg::IGMP_TYPE_LEAVE;
            s1_msg_in.dst_ip    = igmp_fg_pkg::ALL_ROUTERS_IP;
            s1_msg_in.igmp_code = igmp_fg_pkg::CODE_NONE;
         end
         default: begin
            s1_msg_in.igmp_type = igmp_fg_pkg::IGMP_TYPE_QUERY;
            s1_msg_in.dst_ip    = req_group_addr;
            s1_msg_in.igmp_code = igmp_fg_pkg::CODE_NONE;
         end
      endcase
   end

   // drop requests with an undefined kind
   assign s1_valid_in = req_valid && (req_op != igmp_fg_pkg::OP_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_msg_ff <= s1_msg_in;
      end
   end

   // stage 2: checksum partial sums
   igmp_fg_pkg::msg_type s2_msg_ff;
   logic [18:0] s2_ip_acc_in, s2_ip_acc_ff;
   logic [17:0] s2_ig_acc_in, s2_ig_acc_ff;

   assign s2_ip_acc_in = {3'b0, igmp_fg_pkg::IP_CONST_SUM}
                       + {3'b0, source_ip_ff[31:16]} + {3'b0, source_ip_ff[15:0]}
                       + {3'b0, s1_msg_ff.dst_ip[31:16]} + {3'b0, s1_msg_ff.dst_ip[15:0]};
   assign s2_ig_acc_in = {2'b0, s1_msg_ff.igmp_type, s1_msg_ff.igmp_code}
                       + {2'b0, s1_msg_ff.group[31:16]} + {2'b0, s1_msg_ff.group[15:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s2_msg_ff    <= s1_msg_ff;
         s2_ip_acc_ff <= s2_ip_acc_in;
         s2_ig_acc_ff <= s2_ig_acc_in;
      end
   end

   // stage 3: end-around carry fold and complement
   igmp_fg_pkg::frame_type s3_frame_in, s3_frame_ff;
   logic [16:0] ip_fold1, ig_fold1;
   logic [15:0] ip_fold2, ig_fold2;

   assign ip_fold1 = {1'b0, s2_ip_acc_ff[15:0]} + {14'b0, s2_ip_acc_ff[18:16]};
   assign ip_fold2 = ip_fold1[15:0] + {15'b0, ip_fold1[16]};
   assign ig_fold1 = {1'b0, s2_ig_acc_ff[15:0]} + {15'b0, s2_ig_acc_ff[17:16]};
   assign ig_fold2 = ig_fold1[15:0] + {15'b0, ig_fold1[16]};

   assign s3_frame_in.msg        = s2_msg_ff;
   assign s3_frame_in.ip_cksum   = ~ip_fold2;
   assign s3_frame_in.igmp_cksum = ~ig_fold2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s3_frame_ff <= s3_frame_in;
      end
   end

   // byte serializer
   igmp_fg_pkg::frame_type ser_frame_ff;
   logic        ser_tagged_ff;
   logic [5:0]  ser_pos_ff, ser_pos_in;
   logic        ser_valid_in;
   logic [5:0]  byte_idx;
   logic [7:0]  ser_byte;

   assign ser_last = ser_tagged_ff ? (ser_pos_ff == igmp_fg_pkg::LAST_POS_TAGGED)
                                   : (ser_pos_ff == igmp_fg_pkg::LAST_POS_UNTAGGED);

   always_comb begin
      ser_valid_in = ser_valid_ff;
      ser_pos_in   = ser_pos_ff;
      if (ser_emit) begin
         if (ser_last) begin
            ser_valid_in = 1'b0;
            ser_pos_in   = '0;
         end else begin
            ser_pos_in = ser_pos_ff + 6'd1;
         end
      end
      if (s3_ready && s3_valid_ff) begin
         ser_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         ser_pos_ff   <= '0;
      end else begin
         ser_valid_ff <= ser_valid_in;
         ser_pos_ff   <= ser_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         ser_frame_ff  <= s3_frame_ff;
         ser_tagged_ff <= (vlan_id_ff != '0);
      end
   end

   // map the untagged layout onto the tagged one
   assign byte_idx = (ser_tagged_ff || ser_pos_ff < igmp_fg_pkg::ETH_ADDR_END)
                   ? ser_pos_ff : ser_pos_ff + igmp_fg_pkg::VLAN_TAG_BYTES;

   always_comb begin
      case (byte_idx)
         6'd0:  ser_byte = igmp_fg_pkg::MCAST_MAC_0;
         6'd1:  ser_byte = igmp_fg_pkg::MCAST_MAC_1;
         6'd2:  ser_byte = igmp_fg_pkg::MCAST_OUI_LOW;
         6'd3:  ser_byte = {1'b0, ser_frame_ff.msg.dst_ip[22:16]
                                  & igmp_fg_pkg::MCAST_MAC_MASK};
         6'd4:  ser_byte = ser_frame_ff.msg.dst_ip[15:8];
         6'd5:  ser_byte = ser_frame_ff.msg.dst_ip[7:0];
         6'd6:  ser_byte = source_mac_ff[47:40];
         6'd7:  ser_byte = source_mac_ff[39:32];
         6'd8:  ser_byte = source_mac_ff[31:24];
         6'd9:  ser_byte = source_mac_ff[23:16];
         6'd10: ser_byte = source_mac_ff[15:8];
         6'd11: ser_byte = source_mac_ff[7:0];
         6'd12: ser_byte = igmp_fg_pkg::ETYPE_VLAN[15:8];
         6'd13: ser_byte = igmp_fg_pkg::ETYPE_VLAN[7:0];
         6'd14: ser_byte = {4'b0, vlan_id_ff[11:8]};
         6'd15: ser_byte = vlan_id_ff[7:0];
         6'd16: ser_byte = igmp_fg_pkg::ETYPE_IPV4[15:8];
         6'd17: ser_byte = igmp_fg_pkg::ETYPE_IPV4[7:0];
         6'd18: ser_byte = igmp_fg_pkg::IP_VER_IHL;
         6'd19: ser_byte = igmp_fg_pkg::IP_TOS;
         6'd20: ser_byte = igmp_fg_pkg::IP_TOTAL_LEN[15:8];
         6'd21: ser_byte = igmp_fg_pkg::IP_TOTAL_LEN[7:0];
         6'd22: ser_byte = igmp_fg_pkg::IP_IDENT[15:8];
         6'd23: ser_byte = igmp_fg_pkg::IP_IDENT[7:0];
         6'd24: ser_byte = igmp_fg_pkg::IP_FRAG[15:8];
         6'd25: ser_byte = igmp_fg_pkg::IP_FRAG[7:0];
         6'd26: ser_byte = igmp_fg_pkg::IP_TTL;
         6'd27: ser_byte = igmp_fg_pkg::IP_PROTO_IGMP;
         6'd28: ser_byte = ser_frame_ff.ip_cksum[15:8];
         6'd29: ser_byte = ser_frame_ff.ip_cksum[7:0];
         6'd30: ser_byte = source_ip_ff[31:24];
         6'd31: ser_byte = source_ip_ff[23:16];
         6'd32: ser_byte = source_ip_ff[15:8];
         6'd33: ser_byte = source_ip_ff[7:0];
         6'd34: ser_byte = ser_frame_ff.msg.dst_ip[31:24];
         6'd35: ser_byte = ser_frame_ff.msg.dst_ip[23:16];
         6'd36: ser_byte = ser_frame_ff.msg.dst_ip[15:8];
         6'd37: ser_byte = ser_frame_ff.msg.dst_ip[7:0];
         6'd38: ser_byte = igmp_fg_pkg::ROUTER_ALERT_WORD[31:24];
         6'd39: ser_byte = igmp_fg_pkg::ROUTER_ALERT_WORD[23:16];
         6'd40: ser_byte = igmp_fg_pkg::ROUTER_ALERT_WORD[15:8];
         6'd41: ser_byte = igmp_fg_pkg::ROUTER_ALERT_WORD[7:0];
         6'd42: ser_byte = ser_frame_ff.msg.igmp_type;
         6'd43: ser_byte = ser_frame_ff.msg.igmp_code;
         6'd44: ser_byte = ser_frame_ff.igmp_cksum[15:8];
         6'd45: ser_byte = ser_frame_ff.igmp_cksum[7:0];
         6'd46: ser_byte = ser_frame_ff.msg.group[31:24];
         6'd47: ser_byte = ser_frame_ff.msg.group[23:16];
         6'd48: ser_byte = ser_frame_ff.msg.group[15:8];
         6'd49: ser_byte = ser_frame_ff.msg.group[7:0];
         default: ser_byte = 8'h00;
      endcase
   end

   // output register
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= ser_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_emit) begin
         rsp_byte_ff <= ser_byte;
         rsp_last_ff <= ser_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_last_byte  = rsp_last_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      ser_valid_ff |-> (ser_pos_ff <= igmp_fg_pkg::LAST_POS_TAGGED))
      else $error("serializer position out of frame");

   a_idle_pos: assert property (@(posedge clock) disable iff (reset)
      !ser_valid_ff |-> (ser_pos_ff == '0))
      else $error("idle serializer not at frame start");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_ready) |-> (!ser_valid_ff || (ser_emit && ser_last)))
      else $error("serializer loaded mid-frame");

   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_ready) |=> (ser_valid_ff && ser_pos_ff == '0))
      else $error("new frame does not start at byte zero");

   a_last_end: assert property (@(posedge clock) disable iff (reset)
      (ser_emit && ser_last) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("final byte not presented");

endmodule

`default_nettype wire

// File: test/igmp_frame_checker.sv
`timescale 1ns / 1ps

module igmp_frame_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_group_addr,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [7:0]  rsp_frame_byte,
   input  wire logic        rsp_last_byte,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [igmp_fg_pkg::CSR_DATA_WIDTH-1:0] csr_wdata,
   output int unsigned      mismatch_count,
   output int unsigned      bytes_outstanding
);

   localparam logic [31:0] ALERT_OPTION      = 32'h9404_0000;
   localparam logic [31:0] GROUP_ALL_ROUTERS = 32'hE000_0002;
   localparam logic [31:0] GROUP_ALL_HOSTS   = 32'hE000_0001;
   localparam logic [15:0] ETHERTYPE_IP      = 16'h0800;
   localparam logic [15:0] ETHERTYPE_TAG     = 16'h8100;
   localparam logic [7:0]  KIND_QUERY        = 8'h11;
   localparam logic [7:0]  KIND_REPORT       = 8'h16;
   localparam logic [7:0]  KIND_LEAVE        = 8'h17;
   localparam logic [7:0]  MAX_RESP_GROUP    = 8'd10;
   localparam logic [7:0]  MAX_RESP_GENERAL  = 8'd100;

   logic [47:0] station_mac;
   logic [31:0] station_ip;
   logic [11:0] tag_id;
   logic [31:0] held_group;
   igmp_fg_pkg::op_type held_kind;

   // each entry: {last, byte}
   logic [8:0]  frame_bytes_q [$];

   function automatic logic [15:0] fold_and_invert(input logic [31:0] acc);
      logic [31:0] a;
      a = acc;
      while (a[31:16] != 16'h0000)
         a = {16'h0000, a[15:0]} + {16'h0000, a[31:16]};
      return ~a[15:0];
   endfunction

   task automatic report(input string what, input logic [8:0] got, input logic [8:0] want);
      $display("MISMATCH at %0t ns: %s: got %h, want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic queue_frame(input igmp_fg_pkg::op_type kind, input logic [31:0] grp);
      logic [31:0]  dst;
      logic [7:0]   kind_code;
      logic [7:0]   resp_code;
      logic [31:0]  acc;
      logic [15:0]  igmp_ck;
      logic [15:0]  ip_ck;
      logic [47:0]  eth_dst;
      logic [191:0] ip_hdr;
      logic [63:0]  igmp_msg;
      logic [399:0] frame;
      int           len;
      if (kind == igmp_fg_pkg::OP_LEAVE)
         dst = GROUP_ALL_ROUTERS;
      else if (kind == igmp_fg_pkg::OP_QUERY && grp == 32'h0)
         dst = GROUP_ALL_HOSTS;
      else
         dst = grp;
      case (kind)
         igmp_fg_pkg::OP_QUERY:  kind_code = KIND_QUERY;
         igmp_fg_pkg::OP_REPORT: kind_code = KIND_REPORT;
         default:                kind_code = KIND_LEAVE;
      endcase
      if (kind == igmp_fg_pkg::OP_QUERY)
         resp_code = (grp != 32'h0) ? MAX_RESP_GROUP : MAX_RESP_GENERAL;
      else
         resp_code = 8'h00;

      acc = {16'h0000, kind_code, resp_code} + {16'h0000, grp[31:16]}
            + {16'h0000, grp[15:0]};
      igmp_ck = fold_and_invert(acc);

      acc = 32'h4600 + 32'h0020 + 32'h0001 + 32'h0000 + 32'h0102
            + {16'h0000, station_ip[31:16]} + {16'h0000, station_ip[15:0]}
            + {16'h0000, dst[31:16]} + {16'h0000, dst[15:0]}
            + {16'h0000, ALERT_OPTION[31:16]} + {16'h0000, ALERT_OPTION[15:0]};
      ip_ck = fold_and_invert(acc);

      eth_dst  = {8'h01, 8'h00, 8'h5E, 1'b0, dst[22:16], dst[15:8], dst[7:0]};
      ip_hdr   = {8'h46, 8'h00, 16'd32, 16'd1, 16'd0, 8'd1, 8'd2, ip_ck,
                  station_ip, dst, ALERT_OPTION};
      igmp_msg = {kind_code, resp_code, igmp_ck, grp};

      if (tag_id != 12'h000) begin
         frame = {eth_dst, station_mac, ETHERTYPE_TAG, 4'h0, tag_id, ETHERTYPE_IP,
                  ip_hdr, igmp_msg};
         len = 50;
      end else begin
         frame = {eth_dst, station_mac, ETHERTYPE_IP, ip_hdr, igmp_msg, 32'h0};
         len = 46;
      end
      for (int i = 0; i < len; i++)
         frame_bytes_q.push_back({(i == len - 1), frame[399 - 8 * i -: 8]});
   endtask

   always @(posedge clock) begin
      logic [8:0] want;
      if (reset) begin
         frame_bytes_q.delete();
         station_mac = '0;
         station_ip  = '0;
         tag_id      = '0;
         held_group  = '0;
         held_kind   = igmp_fg_pkg::OP_QUERY;
      end else begin
         if (csr_we) begin
            case (igmp_fg_pkg::csr_index_type'(csr_index))
               igmp_fg_pkg::CSR_SOURCE_MAC: station_mac = csr_wdata[47:0];
               igmp_fg_pkg::CSR_SOURCE_IP:  station_ip  = csr_wdata[31:0];
               igmp_fg_pkg::CSR_VLAN_ID:    tag_id      = csr_wdata[11:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready
             && igmp_fg_pkg::op_type'(req_operation) != igmp_fg_pkg::OP_NONE) begin
            held_kind  = igmp_fg_pkg::op_type'(req_operation);
            held_group = req_group_addr;
            queue_frame(held_kind, held_group);
         end
         if (rsp_valid && rsp_ready) begin
            if (frame_bytes_q.size() == 0) begin
               report("frame byte with no request pending", {rsp_last_byte, rsp_frame_byte},
                      9'h000);
            end else begin
               want = frame_bytes_q.pop_front();
               if (rsp_frame_byte !== want[7:0])
                  report("frame byte", {rsp_last_byte, rsp_frame_byte}, want);
               if (rsp_last_byte !== want[8])
                  report("last byte mark", {rsp_last_byte, rsp_frame_byte}, want);
            end
         end
      end
      bytes_outstanding <= frame_bytes_q.size();
   end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 400;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   igmp_fg_pkg::op_type        req_operation;
   logic [31:0]   req_group_addr;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [7:0]    rsp_frame_byte;
   logic          rsp_last_byte;
   logic          csr_we;
   igmp_fg_pkg::csr_index_type csr_index;
   logic [igmp_fg_pkg::CSR_DATA_WIDTH-1:0] csr_wdata;

   int unsigned   mismatch_count;
   int unsigned   bytes_outstanding;

   int            quiet_cycles;
   int            send_calm;
   int            n_query;
   int            n_report;
   int            n_leave;
   int            n_undefined;
   int            n_settings;
   int            rx_bytes;
   int            n_hold_offs;

   igmp_frame_generator i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_group_addr (req_group_addr),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   igmp_frame_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_group_addr    (req_group_addr),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_last_byte     (rsp_last_byte),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .bytes_outstanding (bytes_outstanding)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send(input igmp_fg_pkg::op_type kind, input logic [31:0] grp);
      int gap;
      if (send_calm > 0) begin
         gap = 0;
         send_calm--;
      end else begin
         gap = $urandom_range(0, 17);
         if ($urandom_range(0, 9) == 0)
            send_calm = $urandom_range(5, 30);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= kind;
      req_group_addr <= grp;
      do @(posedge clock); while (!req_ready);
      case (kind)
         igmp_fg_pkg::OP_QUERY:  n_query++;
         igmp_fg_pkg::OP_REPORT: n_report++;
         igmp_fg_pkg::OP_LEAVE:  n_leave++;
         default:                n_undefined++;
      endcase
   endtask

   // drop valid, wait out every pending byte, then let a dropped request clear
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (bytes_outstanding != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic put_reg(input igmp_fg_pkg::csr_index_type idx,
                          input logic [igmp_fg_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [47:0] mac, input logic [47:0] ip,
                               input logic [47:0] vlan);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      settle();
      put_reg(igmp_fg_pkg::CSR_SOURCE_MAC, mac);
      put_reg(igmp_fg_pkg::CSR_SOURCE_IP, ip);
      put_reg(igmp_fg_pkg::CSR_VLAN_ID, vlan);
      put_reg(igmp_fg_pkg::CSR_UNUSED, junk[47:0]);
      csr_we <= 1'b0;
      n_settings++;
   endtask

   task automatic random_requests(input int count);
      igmp_fg_pkg::op_type kind;
      logic [31:0] grp;
      logic [31:0] r;
      int          pick;
      int          n;
      n = 0;
      while (n < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 6)
            kind = igmp_fg_pkg::OP_NONE;
         else
            kind = igmp_fg_pkg::op_type'(2'($urandom_range(0, 2)));
         pick = $urandom_range(0, 99);
         r = $urandom;
         if (pick < 10)
            grp = 32'h0000_0000;
         else if (pick < 22)
            grp = r;
         else if (pick < 27)
            grp = r[0] ? 32'hFFFF_FFFF : 32'hE000_0001;
         else
            grp = {4'hE, r[27:0]};
         send(kind, grp);
         if (kind != igmp_fg_pkg::OP_NONE)
            n++;
      end
   endtask

   function automatic logic [47:0] rand48();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[47:0];
   endfunction

   initial begin : receiver
      int stall;
      int calm;
      rsp_ready   = 1'b0;
      rx_bytes    = 0;
      n_hold_offs = 0;
      calm        = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (rx_bytes == 2000 || rx_bytes == 4500 || rx_bytes == 7000) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            n_hold_offs++;
         end
         if (calm > 0) begin
            stall = 0;
            calm--;
         end else begin
            stall = $urandom_range(0, 17);
            if ($urandom_range(0, 15) == 0)
               calm = $urandom_range(20, 120);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         rx_bytes++;
      end
   end

   initial begin : stimulus
      logic [47:0] tag_data;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = igmp_fg_pkg::OP_QUERY;
      req_group_addr = '0;
      csr_we         = 1'b0;
      csr_index      = igmp_fg_pkg::CSR_SOURCE_MAC;
      csr_wdata      = '0;
      send_calm      = 0;
      n_query        = 0;
      n_report       = 0;
      n_leave        = 0;
      n_undefined    = 0;
      n_settings     = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // registers still at their reset values: untagged, zero addresses
      send(igmp_fg_pkg::OP_QUERY,  32'h0000_0000);
      send(igmp_fg_pkg::OP_QUERY,  32'hFFFF_FFFF);
      send(igmp_fg_pkg::OP_QUERY,  32'hE000_0001);
      send(igmp_fg_pkg::OP_QUERY,  32'h0000_0001);
      send(igmp_fg_pkg::OP_QUERY,  32'h8000_0000);
      send(igmp_fg_pkg::OP_QUERY,  32'hE000_0000);
      send(igmp_fg_pkg::OP_REPORT, 32'h0000_0000);
      send(igmp_fg_pkg::OP_REPORT, 32'hFFFF_FFFF);
      send(igmp_fg_pkg::OP_REPORT, 32'hE07F_0102);
      send(igmp_fg_pkg::OP_REPORT, 32'hE080_0000);
      send(igmp_fg_pkg::OP_REPORT, 32'h7FFF_FFFF);
      send(igmp_fg_pkg::OP_REPORT, 32'hE000_0001);
      send(igmp_fg_pkg::OP_LEAVE,  32'h0000_0000);
      send(igmp_fg_pkg::OP_LEAVE,  32'hFFFF_FFFF);
      send(igmp_fg_pkg::OP_LEAVE,  32'hE000_0002);
      send(igmp_fg_pkg::OP_LEAVE,  32'h1234_5678);
      send(igmp_fg_pkg::OP_NONE,   32'hFFFF_FFFF);
      send(igmp_fg_pkg::OP_NONE,   32'h0000_0000);
      send(igmp_fg_pkg::OP_QUERY,  32'hEFFF_FFFF);
      random_requests(35);

      program_regs(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0FFF);
      random_requests(40);

      program_regs(48'h0, 48'h0, 48'h1);
      random_requests(35);

      // upper data bits only: the id masks to zero, so frames go out untagged
      program_regs(rand48(), rand48(), 48'hFFFF_FFFF_F000);
      random_requests(35);

      tag_data = rand48();
      if (tag_data[11:0] == 12'h000)
         tag_data[0] = 1'b1;
      program_regs(rand48(), rand48(), tag_data);
      random_requests(40);

      settle();
      repeat (20) @(posedge clock);

      $display("covered %0d query, %0d report, %0d leave and %0d undefined requests",
               n_query, n_report, n_leave, n_undefined);
      $display("over %0d register settings; %0d frame bytes received, %0d long hold-offs",
               n_settings, rx_bytes, n_hold_offs);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: filelist.f
rtl/igmp_fg_pkg.sv
rtl/igmp_frame_generator.sv
test/igmp_frame_checker.sv
test/tb.sv
